// ----- hdl/range_count_greater_than_assert.svh -----
// assertion macros for the range count block
// used by the top level, no other dependencies
`ifndef RANGE_COUNT_GREATER_THAN_ASSERT_SVH
`define RANGE_COUNT_GREATER_THAN_ASSERT_SVH

`ifndef SYNTHESIS

`define RCGT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rcgt assertion failed");

`define RCGT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rcgt assertion failed");

`define RCGT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcgt assertion failed");

`else

`define RCGT_ASSERT(lbl, clk, rst_n, prop)
`define RCGT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define RCGT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- hdl/rcgt_pkg.sv -----
// types and constants shared by the range count cells and top level
// no dependencies
package rcgt_pkg;

  localparam int IDX_W = 10;
  localparam int CNT_W = 11;
  localparam int IDX_SPAN = 1 << IDX_W;
  localparam int APB_ADDR_W = 3;

  localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;
  localparam logic REG_ELEMENT_COUNT = 1'b0;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef struct packed {
    logic             valid;
    logic             is_query;
    logic             live;
    logic [IDX_W-1:0] addr;
    logic [IDX_W-1:0] high;
    logic [CNT_W-1:0] count;
  } token_t;

endpackage

// ----- hdl/rcgt_cell.sv -----
// one element cell: holds one stored value, applies passing loads and
// adds its vote to passing queries; depends on rcgt_pkg
module rcgt_cell #(
  parameter int CELL_INDEX = 0,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  rcgt_pkg::token_t      tok_i,
  input  logic [VALUE_BITS-1:0] value_i,
  output rcgt_pkg::token_t      tok_o,
  output logic [VALUE_BITS-1:0] value_o
);
  import rcgt_pkg::*;

  localparam logic [IDX_W-1:0] POS = IDX_W'(CELL_INDEX);

  token_t                tok_d, tok_q;
  logic [VALUE_BITS-1:0] value_q;
  logic [VALUE_BITS-1:0] elem_d, elem_q;
  logic                  hit_load, in_range, greater;

  always_comb begin
    hit_load = tok_i.valid && !tok_i.is_query && (tok_i.addr == POS);
    in_range = tok_i.live && (tok_i.addr <= POS) && (POS <= tok_i.high);
    greater  = $signed(elem_q) > $signed(value_i);
    tok_d    = tok_i;
    if (tok_i.valid && tok_i.is_query && in_range && greater) begin
      tok_d.count = tok_i.count + CNT_W'(1);
    end
    elem_d = hit_load ? value_i : elem_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else if (en_i) begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      value_q <= value_i;
      elem_q  <= elem_d;
    end
  end

  assign tok_o   = tok_q;
  assign value_o = value_q;

endmodule

// ----- hdl/range_count_greater_than.sv -----
// channel  | dir | handshake                       | payload
// s_axis   | in  | s_axis_tvalid / s_axis_tready   | tuser cmd, tdata load and query fields
// m_axis   | out | m_axis_tvalid / m_axis_tready   | tdata greater_count
// apb      | in  | psel, penable, pwrite, pready   | element_count at address 0
// one request enters per cycle while m_axis is not stalled and moves one cell
// per cycle down a row of min(MAX_ELEMENTS, 1024) cells, one stored element
// each; a query result passes every cell and then the output register
// a stall on m_axis freezes the whole row and drops s_axis_tready
// reset clears the row's valid bits and sets element_count to 1024;
// stored values are undefined until loaded
// top level of the range count block; depends on rcgt_pkg and rcgt_cell
`include "range_count_greater_than_assert.svh"

module range_count_greater_than #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int VALUE_BITS   = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // apb configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [rcgt_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  // request stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // lsb up: load_index, load_value, range_low, range_high, threshold, zero pad
  input  logic [((30+2*VALUE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // lsb up: cmd
  input  logic [0:0]                           s_axis_tuser,
  // result stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // lsb up: greater_count, zero pad
  output logic [15:0]                          m_axis_tdata
);
  import rcgt_pkg::*;

  localparam int NUM_CELLS = (MAX_ELEMENTS < IDX_SPAN) ? MAX_ELEMENTS : IDX_SPAN;
  localparam int VAL_LO    = IDX_W;
  localparam int RLO_LO    = VAL_LO + VALUE_BITS;
  localparam int RHI_LO    = RLO_LO + IDX_W;
  localparam int THR_LO    = RHI_LO + IDX_W;

  logic [CNT_W-1:0]      count_d, count_q;
  logic                  cfg_wr;

  logic                  advance;
  logic                  is_query;
  logic [IDX_W-1:0]      load_index, range_low, range_high, hi_eff;
  logic [VALUE_BITS-1:0] load_value, threshold;
  logic [CNT_W-1:0]      lim, lim_m1;

  token_t                tok_in;
  logic [VALUE_BITS-1:0] val_in;
  token_t                tok [NUM_CELLS+1];
  logic [VALUE_BITS-1:0] val [NUM_CELLS+1];

  logic                  out_valid_d, out_valid_q;
  logic [CNT_W-1:0]      out_count_d, out_count_q;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ELEMENT_COUNT);
  assign count_d = cfg_wr ? pwdata[CNT_W-1:0] : count_q;
  assign prdata = (paddr[2] == REG_ELEMENT_COUNT) ? {{(32-CNT_W){1'b0}}, count_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_RESET;
    end else begin
      count_q <= count_d;
    end
  end

  // request decode and range clipping
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = advance;

  always_comb begin
    is_query   = (s_axis_tuser[0] == CMD_QUERY);
    load_index = s_axis_tdata[IDX_W-1:0];
    load_value = s_axis_tdata[VAL_LO +: VALUE_BITS];
    range_low  = s_axis_tdata[RLO_LO +: IDX_W];
    range_high = s_axis_tdata[RHI_LO +: IDX_W];
    threshold  = s_axis_tdata[THR_LO +: VALUE_BITS];

    if (32'(count_q) > 32'(MAX_ELEMENTS)) begin
      lim = CNT_W'(MAX_ELEMENTS);
    end else begin
      lim = count_q;
    end
    lim_m1 = lim - CNT_W'(1);
    if ({1'b0, range_high} > lim_m1) begin
      hi_eff = lim_m1[IDX_W-1:0];
    end else begin
      hi_eff = range_high;
    end

    tok_in.valid    = s_axis_tvalid;
    tok_in.is_query = is_query;
    tok_in.live     = is_query && (lim != '0) && (range_low <= hi_eff);
    tok_in.addr     = is_query ? range_low : load_index;
    tok_in.high     = hi_eff;
    tok_in.count    = '0;
    val_in          = is_query ? threshold : load_value;
  end

  assign tok[0] = tok_in;
  assign val[0] = val_in;

  // row of element cells
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    rcgt_cell #(
      .CELL_INDEX (i),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (advance),
      .tok_i   (tok[i]),
      .value_i (val[i]),
      .tok_o   (tok[i+1]),
      .value_o (val[i+1])
    );
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    out_count_d = out_count_q;
    if (advance) begin
      out_valid_d = tok[NUM_CELLS].valid && tok[NUM_CELLS].is_query;
      out_count_d = tok[NUM_CELLS].count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_count_q <= out_count_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(16-CNT_W){1'b0}}, out_count_q};

  `RCGT_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, out_valid_q, out_count_q <= CNT_W'(NUM_CELLS))
  `RCGT_ASSERT_NEXT(a_row_frozen, clk_i, rst_ni, !advance, $stable(tok[NUM_CELLS]))
  `RCGT_ASSERT_NEXT(a_load_silent, clk_i, rst_ni,
                    advance && tok[NUM_CELLS].valid && !tok[NUM_CELLS].is_query,
                    !out_valid_q)
  `RCGT_ASSERT_IMPL(a_dead_zero, clk_i, rst_ni,
                    tok[NUM_CELLS].valid && !tok[NUM_CELLS].live,
                    tok[NUM_CELLS].count == '0)

endmodule
